/* src/sws_pkg.sv */
`timescale 1ns / 1ps
package sws_pkg;
    localparam logic [1:0] ADDR_WINDOW_LENGTH = 2'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP,
        ST_INSERT,
        ST_SCAN,
        ST_DIV,
        ST_OUT
    } sws_state_t;
endpackage

/* src/sws_front.sv */
`timescale 1ns / 1ps
module sws_front #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [SAMPLE_WIDTH-1:0] in_data,
    output logic                    q_valid,
    input  logic                    q_ready,
    output logic [SAMPLE_WIDTH-1:0] q_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    logic [SAMPLE_WIDTH-1:0] fifo_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] cnt_reg;
    logic push, pop;

    assign in_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_data = fifo_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wp_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH)) else $error("queue overflow");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> !pop) else $error("pop on empty");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == (AW+1)'(DEPTH)) |-> !push) else $error("push on full");
endmodule

/* src/sws_back.sv */
`timescale 1ns / 1ps
module sws_back #(
    parameter int MAX_WINDOW = 16,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [4:0]              win_len,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  logic [SAMPLE_WIDTH-1:0] q_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [4:0]              out_count,
    output logic [SAMPLE_WIDTH-1:0] out_mean,
    output logic [SAMPLE_WIDTH-1:0] out_median,
    output logic [SAMPLE_WIDTH-1:0] out_min,
    output logic [SAMPLE_WIDTH-1:0] out_max
);
    import sws_pkg::*;
    localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int HW = $clog2(MAX_WINDOW + 1);
    localparam int SW = SAMPLE_WIDTH + HW + 1;
    localparam int QW = SW;

    sws_state_t state_reg, state_next;
    logic signed [SAMPLE_WIDTH-1:0] ring_reg [MAX_WINDOW];
    logic [PW-1:0] old_reg;
    logic [HW-1:0] held_reg;
    logic signed [SW-1:0] sum_reg;
    logic [HW-1:0] len_eff;
    logic [HW-1:0] i_reg, j_reg;
    logic signed [SAMPLE_WIDTH-1:0] lo_reg, hi_reg;
    logic [HW-1:0] rank_lt_reg, rank_le_reg;
    logic signed [SAMPLE_WIDTH-1:0] cand_reg;
    logic signed [SAMPLE_WIDTH:0] med_sum_reg;
    logic got_a_reg, got_b_reg;
    logic signed [SAMPLE_WIDTH-1:0] ma_reg, mb_reg;
    logic [SW-1:0] dvd_reg;
    logic [QW-1:0] quo_reg;
    logic [SW-1:0] rem_reg;
    logic [$clog2(QW+1)-1:0] dcnt_reg;
    logic neg_reg;
    logic [4:0] cnt_o_reg;
    logic [SAMPLE_WIDTH-1:0] mean_o_reg, med_o_reg, min_o_reg, max_o_reg;
    logic ov_reg;
    logic [HW-1:0] ta, tb;
    logic [PW-1:0] idx_i, idx_j;
    logic signed [SAMPLE_WIDTH-1:0] vi, vj;
    logic [SW-1:0] rem_sh;
    logic signed [SAMPLE_WIDTH:0] med_half;

    function automatic logic [PW-1:0] ring_idx(logic [PW-1:0] base, logic [HW-1:0] ofs);
        logic [HW:0] s;
        s = (HW+1)'(base) + (HW+1)'(ofs);
        if (s >= (HW+1)'(MAX_WINDOW))
            s = s - (HW+1)'(MAX_WINDOW);
        return PW'(s);
    endfunction

    always_comb
    begin
        if (win_len == '0)
            len_eff = HW'(1);
        else if (32'(win_len) > MAX_WINDOW)
            len_eff = HW'(MAX_WINDOW);
        else
            len_eff = HW'(win_len);
    end

    assign idx_i = ring_idx(old_reg, i_reg);
    assign idx_j = ring_idx(old_reg, j_reg);
    assign vi = ring_reg[idx_i];
    assign vj = ring_reg[idx_j];
    assign ta = HW'((held_reg - 1'b1) >> 1);
    assign tb = HW'(held_reg >> 1);
    assign rem_sh = {rem_reg[SW-2:0], dvd_reg[SW-1]};
    assign med_half = (med_sum_reg + ((med_sum_reg < 0) ? 1 : 0)) >>> 1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (q_valid) state_next = ST_DROP;
            ST_DROP:   if (!(held_reg >= len_eff && held_reg != '0)) state_next = ST_INSERT;
            ST_INSERT: state_next = ST_SCAN;
            ST_SCAN:   if (i_reg == held_reg - 1'b1 && j_reg == held_reg - 1'b1)
                           state_next = ST_DIV;
            ST_DIV:    if (dcnt_reg == '0) state_next = ST_OUT;
            ST_OUT:    if (!ov_reg) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_ready = (state_reg == ST_IDLE);
    end

    assign out_valid = ov_reg;
    assign out_count = cnt_o_reg;
    assign out_mean = mean_o_reg;
    assign out_median = med_o_reg;
    assign out_min = min_o_reg;
    assign out_max = max_o_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_INSERT)
        begin
            ring_reg[ring_idx(old_reg, held_reg)] <= cand_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            old_reg <= '0;
            held_reg <= '0;
            sum_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                        cand_reg <= q_data;
                end
                ST_DROP:
                begin
                    if (held_reg >= len_eff && held_reg != '0)
                    begin
                        sum_reg <= sum_reg - SW'(ring_reg[old_reg]);
                        old_reg <= (old_reg == PW'(MAX_WINDOW-1)) ? '0 : old_reg + 1'b1;
                        held_reg <= held_reg - 1'b1;
                    end
                end
                ST_INSERT:
                begin
                    held_reg <= held_reg + 1'b1;
                    sum_reg <= sum_reg + SW'(cand_reg);
                    lo_reg <= cand_reg;
                    hi_reg <= cand_reg;
                    i_reg <= '0;
                    j_reg <= '0;
                    rank_lt_reg <= '0;
                    rank_le_reg <= '0;
                    got_a_reg <= 1'b0;
                    got_b_reg <= 1'b0;
                end
                ST_SCAN:
                begin
                    if (j_reg == '0)
                    begin
                        if (vi < lo_reg) lo_reg <= vi;
                        if (vi > hi_reg) hi_reg <= vi;
                    end
                    if (j_reg == held_reg - 1'b1)
                    begin
                        // element i occupies sorted ranks [lt, le)
                        if (!got_a_reg && ta >= rank_lt_reg + HW'(vj < vi)
                            && ta < rank_le_reg + HW'(vj <= vi))
                        begin
                            ma_reg <= vi;
                            got_a_reg <= 1'b1;
                        end
                        if (!got_b_reg && tb >= rank_lt_reg + HW'(vj < vi)
                            && tb < rank_le_reg + HW'(vj <= vi))
                        begin
                            mb_reg <= vi;
                            got_b_reg <= 1'b1;
                        end
                        rank_lt_reg <= '0;
                        rank_le_reg <= '0;
                        j_reg <= '0;
                        i_reg <= i_reg + 1'b1;
                        if (i_reg == held_reg - 1'b1)
                        begin
                            neg_reg <= sum_reg[SW-1];
                            dvd_reg <= sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
                            rem_reg <= '0;
                            quo_reg <= '0;
                            dcnt_reg <= ($clog2(QW+1))'(SW);
                        end
                    end
                    else
                    begin
                        rank_lt_reg <= rank_lt_reg + HW'(vj < vi);
                        rank_le_reg <= rank_le_reg + HW'(vj <= vi);
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_DIV:
                begin
                    if (dcnt_reg == SW)
                        med_sum_reg <= held_reg[0] ? $signed({mb_reg, 1'b0})
                                                   : (SAMPLE_WIDTH+1)'(ma_reg)
                                                     + (SAMPLE_WIDTH+1)'(mb_reg);
                    if (dcnt_reg != '0)
                    begin
                        dvd_reg <= dvd_reg << 1;
                        if (rem_sh >= SW'(held_reg))
                        begin
                            rem_reg <= rem_sh - SW'(held_reg);
                            quo_reg <= {quo_reg[QW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[QW-2:0], 1'b0};
                        end
                        dcnt_reg <= dcnt_reg - 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (!ov_reg)
                    begin
                        ov_reg <= 1'b1;
                        cnt_o_reg <= 5'(held_reg);
                        mean_o_reg <= SAMPLE_WIDTH'(neg_reg ? -quo_reg : quo_reg);
                        med_o_reg <= SAMPLE_WIDTH'(med_half);
                        min_o_reg <= lo_reg;
                        max_o_reg <= hi_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    a_held: assert property (@(posedge clk) disable iff (!rst_n)
        32'(held_reg) <= MAX_WINDOW) else $error("held count overflow");
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (cnt_o_reg != '0)) else $error("empty result");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> ov_reg && $stable(mean_o_reg))
        else $error("result dropped");
endmodule

/* src/sliding_window_statistics.sv */
`timescale 1ns / 1ps
// Each sample is processed in turn: the oldest samples are retired while the
// window is full, the new one is inserted, a rank scan over every pair of held
// samples finds min, max and median, then a 38-bit serial divide of the running
// sum by the count gives the mean. A new sample enters the core only once the
// last result has moved into the output register; a two-entry input queue and
// the output register let both sides stall independently.
// Reset (rst_n async low): window empty, window_length 16.
module sliding_window_statistics #(
    parameter int MAX_WINDOW = 16,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [SAMPLE_WIDTH-1:0] s_axis_tdata, // sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // fill_count(5), mean, median, min, max, zero padded to whole bytes
    output logic [((5+4*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
    import sws_pkg::*;
    logic [4:0] wlen_reg;
    logic q_valid, q_ready;
    logic [SAMPLE_WIDTH-1:0] q_data;
    logic [4:0] cnt;
    logic [SAMPLE_WIDTH-1:0] mn, md, lo, hi;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_WINDOW_LENGTH) ? {27'd0, wlen_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wlen_reg <= 5'd16;
        else if (psel && penable && pwrite && paddr == ADDR_WINDOW_LENGTH)
            wlen_reg <= pwdata[4:0];
    end

    sws_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .DEPTH(2)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    sws_back #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n), .win_len(wlen_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_count(cnt), .out_mean(mn), .out_median(md), .out_min(lo), .out_max(hi)
    );

    assign m_axis_tdata = ($bits(m_axis_tdata))'({hi, lo, md, mn, cnt});
endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import sws_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [4:0]  fill;
        logic [31:0] mean;
        logic [31:0] median;
        logic [31:0] lo;
        logic [31:0] hi;
    } stats_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [8+4*32-1:0] m_axis_tdata;

    sliding_window_statistics uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // predictor state
    logic [4:0]         win_len_reg;
    logic signed [31:0] ring [16];
    int unsigned        oldest = 0;
    int unsigned        held = 0;
    longint             sum = 0;

    logic [31:0] sample_queue [$];
    stats_t      expected_stats [$];
    int          errors = 0;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;
    int          idle_cycles = 0;
    logic [4:0]  lens [8] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd7, 5'd17, 5'd16};

    function automatic stats_t window_stats(logic [31:0] raw);
        stats_t r;
        int unsigned len;
        longint srt [16];
        longint key;
        longint v;
        longint lo;
        longint hi;
        longint med;
        int j;
        len = (win_len_reg == 0) ? 1 : ((win_len_reg > 16) ? 16 : win_len_reg);
        while (held >= len && held > 0)
        begin
            sum -= ring[oldest];
            oldest = (oldest + 1) % 16;
            held--;
        end
        ring[(oldest + held) % 16] = raw;
        held++;
        sum += longint'($signed(raw));
        lo = $signed(raw);
        hi = lo;
        for (int i = 0; i < held; i++)
        begin
            v = ring[(oldest + i) % 16];
            srt[i] = v;
            if (v < lo) lo = v;
            if (v > hi) hi = v;
        end
        for (int i = 1; i < held; i++)
        begin
            key = srt[i];
            j = i;
            while (j > 0 && srt[j-1] > key)
            begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = key;
        end
        if (held % 2 == 0)
            med = (srt[held/2-1] + srt[held/2]) / 2;
        else
            med = srt[held/2];
        r.fill = held[4:0];
        r.mean = 32'(sum / longint'(held));
        r.median = 32'(med);
        r.lo = 32'(lo);
        r.hi = 32'(hi);
        return r;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sample_queue.delete(0);
            if ((sample_queue.size() > 0) && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= sample_queue[0];
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // predict on acceptance
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            expected_stats.insert(expected_stats.size(), window_stats(s_axis_tdata));
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        stats_t e;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_stats.size() == 0)
                begin
                    $error("result with nothing expected");
                    errors++;
                end
                else
                begin
                    e = expected_stats[0];
                    expected_stats.delete(0);
                    if (m_axis_tdata[4:0] !== e.fill)
                    begin
                        $error("fill_count exp %0d got %0d", e.fill, m_axis_tdata[4:0]);
                        errors++;
                    end
                    if (m_axis_tdata[36:5] !== e.mean)
                    begin
                        $error("window_mean exp %h got %h", e.mean, m_axis_tdata[36:5]);
                        errors++;
                    end
                    if (m_axis_tdata[68:37] !== e.median)
                    begin
                        $error("window_median exp %h got %h", e.median,
                               m_axis_tdata[68:37]);
                        errors++;
                    end
                    if (m_axis_tdata[100:69] !== e.lo)
                    begin
                        $error("window_min exp %h got %h", e.lo, m_axis_tdata[100:69]);
                        errors++;
                    end
                    if (m_axis_tdata[132:101] !== e.hi)
                    begin
                        $error("window_max exp %h got %h", e.hi, m_axis_tdata[132:101]);
                        errors++;
                    end
                end
            end
            m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sliding_window_statistics regression: fail");
            $finish;
        end
    end

    task automatic apb_write(logic [1:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_WINDOW_LENGTH)
            win_len_reg = data[4:0];
    endtask

    task automatic drain();
        wait (sample_queue.size() == 0 && !s_axis_tvalid && expected_stats.size() == 0);
        repeat (400) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(5))
            0: return 32'h7fffffff - $urandom_range(3);
            1: return 32'h80000000 + $urandom_range(3);
            2: return $urandom_range(20) - 10;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_phase(int n, int sidle, int rstall);
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        for (int i = 0; i < n; i++)
            sample_queue.insert(sample_queue.size(), rand_sample());
        drain();
    endtask

    initial
    begin
        rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        win_len_reg = 16;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, even/odd medians, full window at reset length
        sample_queue.insert(sample_queue.size(), 32'h7fffffff);
        sample_queue.insert(sample_queue.size(), 32'h7fffffff);
        sample_queue.insert(sample_queue.size(), 32'h80000000);
        sample_queue.insert(sample_queue.size(), 32'h80000000);
        sample_queue.insert(sample_queue.size(), 32'hffffffff);
        sample_queue.insert(sample_queue.size(), 32'h00000001);
        sample_queue.insert(sample_queue.size(), 32'h00000000);
        sample_queue.insert(sample_queue.size(), 32'hfffffffd);
        for (int i = 0; i < 12; i++)
            sample_queue.insert(sample_queue.size(), 32'h7ffffff0 + i);
        drain();
        // shrink while full, then grow
        apb_write(ADDR_WINDOW_LENGTH, 32'd3);
        run_phase(6, 0, 0);
        apb_write(ADDR_WINDOW_LENGTH, 32'd0);
        run_phase(4, 0, 0);
        apb_write(ADDR_WINDOW_LENGTH, 32'hffffffff);
        run_phase(20, 0, 0);
        apb_write(2'd1, 32'd4);
        run_phase(4, 0, 0);

        // pressure: receiver holds off while sender keeps offering
        hold_off = 1;
        send_idle_pct = 0;
        for (int i = 0; i < 20; i++)
            sample_queue.insert(sample_queue.size(), rand_sample());
        repeat (3000) @(posedge clk);
        hold_off = 0;
        drain();

        for (int p = 0; p < 8; p++)
        begin
            apb_write(ADDR_WINDOW_LENGTH, (p % 2) ? lens[p] : $urandom_range(31));
            run_phase(45, 0, 0);
            run_phase(45, 88, 0);
            run_phase(45, 0, 88);
            run_phase(45, 27, 27);
        end

        if (errors == 0)
            $display("sliding_window_statistics regression: pass");
        else
            $display("sliding_window_statistics regression: fail");
        $finish;
    end
endmodule
